// ===== rtl/fixed_point_trig_polynomial_unit_top_defines.svh =====
// Assertion macros shared by the trig polynomial unit RTL.
// Needs a clock named clk and an active-low reset named rst_n in scope.
`ifndef FIXED_POINT_TRIG_POLYNOMIAL_UNIT_TOP_DEFINES_SVH
`define FIXED_POINT_TRIG_POLYNOMIAL_UNIT_TOP_DEFINES_SVH

// Same-cycle implication
`define FPTPU_ASSERT_NOW(name, ante, cons, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication
`define FPTPU_ASSERT_NEXT(name, ante, cons, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== rtl/fptpu_pkg.sv =====
// Types, widths, angle constants and polynomial coefficients of the trig unit.
// No dependencies.
package fptpu_pkg;

    localparam int FRAC_BITS = 16;
    localparam int OP_W      = 2;
    localparam int X_W       = 20;
    localparam int SQ_W      = 24;
    localparam int LEAD_W    = 15;
    localparam int COEF_W    = 18;
    localparam int R1_W      = 21;
    localparam int R2_W      = 27;
    localparam int R3_W      = 30;
    localparam int R4_W      = 36;
    localparam int R5_W      = 39;
    localparam int VALUE_W   = 18;

    localparam logic [OP_W-1:0] OP_SIN  = 2'd0;
    localparam logic [OP_W-1:0] OP_COS  = 2'd1;
    localparam logic [OP_W-1:0] OP_TAN  = 2'd2;
    localparam logic [OP_W-1:0] OP_ATAN = 2'd3;

    localparam logic [1:0] STEP_A = 2'd0;
    localparam logic [1:0] STEP_B = 2'd1;
    localparam logic [1:0] STEP_C = 2'd2;
    localparam logic [1:0] STEP_D = 2'd3;

    localparam logic signed [X_W:0] FX_PI_HALF  = 21'sd102943;
    localparam logic signed [X_W:0] FX_PI       = 21'sd205887;
    localparam logic signed [X_W:0] FX_PI_3HALF = 21'sd308830;
    localparam logic signed [X_W:0] FX_TWO_PI   = 21'sd411774;

    localparam logic signed [VALUE_W-1:0] VALUE_MAX = 18'sd131071;
    localparam logic signed [VALUE_W-1:0] VALUE_MIN = -18'sd131072;

    typedef struct packed {
        logic [OP_W-1:0]        op;
        logic signed [X_W-1:0]  x;
        logic signed [SQ_W-1:0] sq;
        logic                   neg;
    } fptpu_side_t;

    function automatic logic signed [LEAD_W-1:0] lead_coef(input logic [OP_W-1:0] op);
        logic signed [LEAD_W-1:0] c;
        case (op)
            OP_SIN:  c = 15'sd498;
            OP_COS:  c = 15'sd2328;
            OP_TAN:  c = 15'sd13323;
            default: c = 15'sd1365;
        endcase
        return c;
    endfunction

    function automatic logic signed [COEF_W-1:0] add_coef(input logic [1:0] step,
                                                          input logic [OP_W-1:0] op);
        logic signed [COEF_W-1:0] c;
        case (step)
            STEP_A:
            begin
                case (op)
                    OP_SIN:  c = -18'sd10882;
                    OP_COS:  c = -18'sd32551;
                    OP_TAN:  c = 18'sd20810;
                    default: c = -18'sd5579;
                endcase
            end
            STEP_B:  c = (op == OP_ATAN) ? 18'sd11805 : 18'sd65536;
            STEP_C:  c = (op == OP_ATAN) ? -18'sd21646 : 18'sd0;
            default: c = (op == OP_ATAN) ? 18'sd65527 : 18'sd0;
        endcase
        return c;
    endfunction

endpackage

// ===== rtl/fixed_point_trig_polynomial_unit_top.sv =====
// Throughput: one word per cycle while rsp_stall is low; eight register stages
// (fold, square, four Horner multiply-adds, final multiply by x, sign and saturate).
// Each stage holds its word while the next is full, so bubbles are squeezed out.
// Reset clears every stage's valid flag asynchronously; data registers keep no reset.
`include "fixed_point_trig_polynomial_unit_top_defines.svh"

module fixed_point_trig_polynomial_unit_top
    import fptpu_pkg::*;
(
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      req_valid,
    output logic                      req_stall,
    input  logic [OP_W-1:0]           operation,
    input  logic signed [X_W-1:0]     argument,
    output logic                      rsp_valid,
    input  logic                      rsp_stall,
    output logic signed [VALUE_W-1:0] value
);

    fptpu_side_t s0, s1, s1m, s2, s3, s4, s5, s6;
    logic v0, v1, v2, v3, v4, v5, v6;
    logic st0, st1, st2, st3, st4, st5, st6;
    logic signed [SQ_W-1:0] sq_r;
    logic signed [R1_W-1:0] r1;
    logic signed [R2_W-1:0] r2;
    logic signed [R3_W-1:0] r3;
    logic signed [R4_W-1:0] r4;
    logic signed [R5_W-1:0] r5;

    always_comb
    begin
        s1m    = s1;
        s1m.sq = sq_r;
    end

    fptpu_fold u_fold (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (req_valid),
        .in_stall  (req_stall),
        .operation (operation),
        .argument  (argument),
        .out_valid (v0),
        .out_stall (st0),
        .out_side  (s0)
    );

    // square the folded argument
    fptpu_step #(.RW_IN(X_W), .RW_OUT(SQ_W), .MW(X_W)) u_square (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (v0),
        .in_stall  (st0),
        .in_side   (s0),
        .in_r      (s0.x),
        .in_m      (s0.x),
        .in_coef   ('0),
        .in_bypass (1'b0),
        .out_valid (v1),
        .out_stall (st1),
        .out_side  (s1),
        .out_r     (sq_r)
    );

    fptpu_step #(.RW_IN(LEAD_W), .RW_OUT(R1_W), .MW(SQ_W)) u_step_a (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (v1),
        .in_stall  (st1),
        .in_side   (s1m),
        .in_r      (lead_coef(s1m.op)),
        .in_m      (s1m.sq),
        .in_coef   (add_coef(STEP_A, s1m.op)),
        .in_bypass (1'b0),
        .out_valid (v2),
        .out_stall (st2),
        .out_side  (s2),
        .out_r     (r1)
    );

    fptpu_step #(.RW_IN(R1_W), .RW_OUT(R2_W), .MW(SQ_W)) u_step_b (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (v2),
        .in_stall  (st2),
        .in_side   (s2),
        .in_r      (r1),
        .in_m      (s2.sq),
        .in_coef   (add_coef(STEP_B, s2.op)),
        .in_bypass (1'b0),
        .out_valid (v3),
        .out_stall (st3),
        .out_side  (s3),
        .out_r     (r2)
    );

    // higher terms for arctangent only
    fptpu_step #(.RW_IN(R2_W), .RW_OUT(R3_W), .MW(SQ_W)) u_step_c (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (v3),
        .in_stall  (st3),
        .in_side   (s3),
        .in_r      (r2),
        .in_m      (s3.sq),
        .in_coef   (add_coef(STEP_C, s3.op)),
        .in_bypass (s3.op != OP_ATAN),
        .out_valid (v4),
        .out_stall (st4),
        .out_side  (s4),
        .out_r     (r3)
    );

    fptpu_step #(.RW_IN(R3_W), .RW_OUT(R4_W), .MW(SQ_W)) u_step_d (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (v4),
        .in_stall  (st4),
        .in_side   (s4),
        .in_r      (r3),
        .in_m      (s4.sq),
        .in_coef   (add_coef(STEP_D, s4.op)),
        .in_bypass (s4.op != OP_ATAN),
        .out_valid (v5),
        .out_stall (st5),
        .out_side  (s5),
        .out_r     (r4)
    );

    // odd functions take a final multiply by x; cosine skips it
    fptpu_step #(.RW_IN(R4_W), .RW_OUT(R5_W), .MW(X_W)) u_step_x (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (v5),
        .in_stall  (st5),
        .in_side   (s5),
        .in_r      (r4),
        .in_m      (s5.x),
        .in_coef   ('0),
        .in_bypass (s5.op == OP_COS),
        .out_valid (v6),
        .out_stall (st6),
        .out_side  (s6),
        .out_r     (r5)
    );

    fptpu_out u_out (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (v6),
        .in_stall  (st6),
        .in_r      (r5),
        .in_neg    (s6.neg),
        .out_valid (rsp_valid),
        .out_stall (rsp_stall),
        .out_value (value)
    );

    `FPTPU_ASSERT_NOW(a_square_nonneg, v1, sq_r >= 0, "squared argument negative")

    `FPTPU_ASSERT_NOW(a_sign_only_trig,
        v6 && s6.neg, s6.op == OP_SIN || s6.op == OP_COS,
        "sign flip on tangent or arctangent")

endmodule

// ===== rtl/fptpu_fold.sv =====
// Input register stage: folds sine and cosine angles into the first quadrant.
// Depends on fptpu_pkg and the assertion macro header.
`include "fixed_point_trig_polynomial_unit_top_defines.svh"

module fptpu_fold
    import fptpu_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    output logic                  in_stall,
    input  logic [OP_W-1:0]       operation,
    input  logic signed [X_W-1:0] argument,
    output logic                  out_valid,
    input  logic                  out_stall,
    output fptpu_side_t           out_side
);

    logic          valid_reg;
    fptpu_side_t   side_reg;
    fptpu_side_t   side_next;
    logic signed [X_W:0] xw;
    logic          trig;

    always_comb
    begin
        xw   = (X_W+1)'(argument);
        trig = (operation == OP_SIN) || (operation == OP_COS);
        side_next.op  = operation;
        side_next.x   = argument;
        side_next.sq  = '0;
        side_next.neg = 1'b0;
        if (trig)
        begin
            if (xw > FX_PI_HALF && xw <= FX_PI)
            begin
                side_next.x   = X_W'(FX_PI - xw);
                side_next.neg = (operation == OP_COS);
            end
            else if (xw > FX_PI && xw <= FX_PI_3HALF)
            begin
                side_next.x   = X_W'(xw - FX_PI);
                side_next.neg = 1'b1;
            end
            else if (xw > FX_PI_3HALF)
            begin
                side_next.x   = X_W'(FX_TWO_PI - xw);
                side_next.neg = (operation == OP_SIN);
            end
        end
    end

    assign in_stall  = valid_reg && out_stall;
    assign out_valid = valid_reg;
    assign out_side  = side_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (!in_stall)
        begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (!in_stall && in_valid)
        begin
            side_reg <= side_next;
        end
    end

    `FPTPU_ASSERT_NOW(a_fold_quadrant,
        valid_reg && (side_reg.op == OP_SIN || side_reg.op == OP_COS),
        (X_W+1)'(side_reg.x) <= FX_PI_HALF, "folded angle above pi/2")

endmodule

// ===== rtl/fptpu_step.sv =====
// One Horner register stage: r * m shifted right by 16, plus a coefficient.
// A bypassed word passes r unchanged. Depends on fptpu_pkg and the macro header.
`include "fixed_point_trig_polynomial_unit_top_defines.svh"

module fptpu_step
    import fptpu_pkg::*;
#(
    parameter int RW_IN  = 20,
    parameter int RW_OUT = 24,
    parameter int MW     = 20
)
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     in_valid,
    output logic                     in_stall,
    input  fptpu_side_t              in_side,
    input  logic signed [RW_IN-1:0]  in_r,
    input  logic signed [MW-1:0]     in_m,
    input  logic signed [COEF_W-1:0] in_coef,
    input  logic                     in_bypass,
    output logic                     out_valid,
    input  logic                     out_stall,
    output fptpu_side_t              out_side,
    output logic signed [RW_OUT-1:0] out_r
);

    localparam int PW = RW_IN + MW;

    logic                     valid_reg;
    fptpu_side_t              side_reg;
    logic signed [RW_OUT-1:0] r_reg;
    logic signed [RW_OUT-1:0] r_next;
    logic signed [PW-1:0]     prod;
    logic signed [PW-1:0]     sum;

    always_comb
    begin
        prod   = PW'(in_r) * PW'(in_m);
        sum    = (prod >>> FRAC_BITS) + PW'(in_coef);
        r_next = in_bypass ? RW_OUT'(in_r) : RW_OUT'(sum);
    end

    assign in_stall  = valid_reg && out_stall;
    assign out_valid = valid_reg;
    assign out_side  = side_reg;
    assign out_r     = r_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (!in_stall)
        begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (!in_stall && in_valid)
        begin
            side_reg <= in_side;
            r_reg    <= r_next;
        end
    end

    `FPTPU_ASSERT_NEXT(a_step_bypass,
        in_valid && !in_stall && in_bypass,
        out_valid && out_r == RW_OUT'($past(in_r)), "bypassed word altered")

endmodule

// ===== rtl/fptpu_out.sv =====
// Output register stage: applies the quadrant sign and saturates to 18 bits.
// Depends on fptpu_pkg.
module fptpu_out
    import fptpu_pkg::*;
(
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      in_valid,
    output logic                      in_stall,
    input  logic signed [R5_W-1:0]    in_r,
    input  logic                      in_neg,
    output logic                      out_valid,
    input  logic                      out_stall,
    output logic signed [VALUE_W-1:0] out_value
);

    localparam logic signed [R5_W:0] SAT_HI = (R5_W+1)'(VALUE_MAX);
    localparam logic signed [R5_W:0] SAT_LO = (R5_W+1)'(VALUE_MIN);

    logic                      valid_reg;
    logic signed [VALUE_W-1:0] value_reg;
    logic signed [VALUE_W-1:0] value_next;
    logic signed [R5_W:0]      mag;
    logic signed [R5_W:0]      signed_r;

    always_comb
    begin
        mag      = (R5_W+1)'(in_r);
        signed_r = in_neg ? -mag : mag;
        if (signed_r > SAT_HI)
        begin
            value_next = VALUE_MAX;
        end
        else if (signed_r < SAT_LO)
        begin
            value_next = VALUE_MIN;
        end
        else
        begin
            value_next = VALUE_W'(signed_r);
        end
    end

    assign in_stall  = valid_reg && out_stall;
    assign out_valid = valid_reg;
    assign out_value = value_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (!in_stall)
        begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (!in_stall && in_valid)
        begin
            value_reg <= value_next;
        end
    end

endmodule

// ===== bench/fixed_point_trig_polynomial_unit_checker.sv =====
`timescale 1ns / 100ps
// Scoreboard for the trig polynomial unit: predicts each signed Q2.16 result word from the
// argument word taken in and compares it, in order, with the word handed out.
// Depends on fptpu_pkg for widths, angle constants and operation codes.
module fixed_point_trig_polynomial_unit_checker
    import fptpu_pkg::*;
(
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      req_valid,
    input  logic                      req_stall,
    input  logic [OP_W-1:0]           operation,
    input  logic signed [X_W-1:0]     argument,
    input  logic                      rsp_valid,
    input  logic                      rsp_stall,
    input  logic signed [VALUE_W-1:0] value,
    output int                        mismatches,
    output int                        outstanding,
    output int                        results_seen
);

    localparam longint FX_ONE  = 65536;
    localparam longint SIN_K2  = 498;
    localparam longint SIN_K1  = -10882;
    localparam longint COS_K2  = 2328;
    localparam longint COS_K1  = -32551;
    localparam longint TAN_K2  = 13323;
    localparam longint TAN_K1  = 20810;
    localparam longint ATAN_K4 = 1365;
    localparam longint ATAN_K3 = -5579;
    localparam longint ATAN_K2 = 11805;
    localparam longint ATAN_K1 = -21646;
    localparam longint ATAN_K0 = 65527;
    localparam int     SHOWN   = 10;

    typedef struct {
        logic [OP_W-1:0]           op;
        logic signed [X_W-1:0]     arg;
        logic signed [VALUE_W-1:0] value;
    } trig_word_t;

    trig_word_t due_values[$];
    trig_word_t fresh;
    trig_word_t oldest;

    function automatic longint fx_mul(input longint a, input longint b);
        return (a * b) >>> FRAC_BITS;
    endfunction

    function automatic logic signed [VALUE_W-1:0] trig_value(input logic [OP_W-1:0] op,
                                                            input logic signed [X_W-1:0] arg);
        longint x;
        longint sq;
        longint r;
        bit     neg;
        x   = longint'(arg);
        neg = 1'b0;
        if (op == OP_SIN || op == OP_COS)
        begin
            if (x > longint'(FX_PI_HALF) && x <= longint'(FX_PI))
            begin
                x   = longint'(FX_PI) - x;
                neg = (op == OP_COS);
            end
            else if (x > longint'(FX_PI) && x <= longint'(FX_PI_3HALF))
            begin
                x   = x - longint'(FX_PI);
                neg = 1'b1;
            end
            else if (x > longint'(FX_PI_3HALF))
            begin
                x   = longint'(FX_TWO_PI) - x;
                neg = (op == OP_SIN);
            end
        end
        sq = fx_mul(x, x);
        case (op)
            OP_SIN:  r = fx_mul(fx_mul(fx_mul(SIN_K2, sq) + SIN_K1, sq) + FX_ONE, x);
            OP_COS:  r = fx_mul(fx_mul(COS_K2, sq) + COS_K1, sq) + FX_ONE;
            OP_TAN:  r = fx_mul(fx_mul(fx_mul(TAN_K2, sq) + TAN_K1, sq) + FX_ONE, x);
            default:
            begin
                r = fx_mul(ATAN_K4, sq) + ATAN_K3;
                r = fx_mul(r, sq) + ATAN_K2;
                r = fx_mul(r, sq) + ATAN_K1;
                r = fx_mul(r, sq) + ATAN_K0;
                r = fx_mul(r, x);
            end
        endcase
        if (neg)
            r = -r;
        if (r > longint'(VALUE_MAX))
            r = longint'(VALUE_MAX);
        if (r < longint'(VALUE_MIN))
            r = longint'(VALUE_MIN);
        return r[VALUE_W-1:0];
    endfunction

    initial
    begin
        mismatches   = 0;
        outstanding  = 0;
        results_seen = 0;
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (req_valid && !req_stall)
            begin
                fresh.op    = operation;
                fresh.arg   = argument;
                fresh.value = trig_value(operation, argument);
                due_values.push_back(fresh);
            end
            if (rsp_valid && !rsp_stall)
            begin
                results_seen++;
                if (due_values.size() == 0)
                begin
                    mismatches++;
                    if (mismatches <= SHOWN)
                        $display("unexpected result word %0d, nothing outstanding", value);
                end
                else
                begin
                    oldest = due_values.pop_front();
                    if (value !== oldest.value)
                    begin
                        mismatches++;
                        if (mismatches <= SHOWN)
                            $display("mismatch: op %0d arg %0d expected %0d got %0d",
                                     oldest.op, oldest.arg, oldest.value, value);
                    end
                end
            end
            outstanding = due_values.size();
        end
    end

endmodule

// ===== bench/fixed_point_trig_polynomial_unit_top_tb.sv =====
`timescale 1ns / 100ps
// Testbench top for the trig polynomial unit: sends argument words in random bursts,
// stalls the result side on shifting patterns and gives the verdict.
// Depends on fptpu_pkg, the unit RTL and fixed_point_trig_polynomial_unit_checker.
module fixed_point_trig_polynomial_unit_top_tb;
    import fptpu_pkg::*;

    localparam int RANDOM_WORDS = 1800;
    localparam int IDLE_LIMIT   = 2000;
    localparam int TAIL_CYCLES  = 16;

    localparam logic signed [X_W-1:0] ARG_MAX    = 20'sh7ffff;
    localparam logic signed [X_W-1:0] ARG_MIN    = 20'sh80000;
    localparam logic signed [X_W-1:0] ARG_ONE    = 20'sd65536;
    localparam logic signed [X_W-1:0] ARG_PI_QTR = 20'sd51472;

    typedef enum logic [1:0] {STALL_NONE, STALL_LIGHT, STALL_HEAVY, STALL_PERIODIC} stall_mode_e;

    logic                      clk       = 1'b0;
    logic                      rst_n;
    logic                      req_valid;
    logic                      req_stall;
    logic [OP_W-1:0]           operation;
    logic signed [X_W-1:0]     argument;
    logic                      rsp_valid;
    logic                      rsp_stall = 1'b0;
    logic signed [VALUE_W-1:0] value;

    int          mismatches;
    int          outstanding;
    int          results_seen;
    int          burst_left;
    int          words_sent [4] = '{0, 0, 0, 0};
    stall_mode_e stall_mode     = STALL_NONE;
    int          stall_span     = 0;
    logic [2:0]  stall_phase    = '0;

    fixed_point_trig_polynomial_unit_top DUT
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_stall (req_stall),
        .operation (operation),
        .argument  (argument),
        .rsp_valid (rsp_valid),
        .rsp_stall (rsp_stall),
        .value     (value)
    );

    fixed_point_trig_polynomial_unit_checker trig_checker
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .req_valid    (req_valid),
        .req_stall    (req_stall),
        .operation    (operation),
        .argument     (argument),
        .rsp_valid    (rsp_valid),
        .rsp_stall    (rsp_stall),
        .value        (value),
        .mismatches   (mismatches),
        .outstanding  (outstanding),
        .results_seen (results_seen)
    );

    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    always @(negedge clk)
    begin
        if (stall_span == 0)
        begin
            stall_mode <= stall_mode_e'($urandom_range(0, 3));
            stall_span <= $urandom_range(20, 200);
        end
        else
            stall_span <= stall_span - 1;
        case (stall_mode)
            STALL_NONE:  rsp_stall <= 1'b0;
            STALL_LIGHT: rsp_stall <= ($urandom_range(0, 3) == 0);
            STALL_HEAVY: rsp_stall <= ($urandom_range(0, 3) != 0);
            default:     rsp_stall <= (stall_phase >= 3'd5);
        endcase
        stall_phase <= stall_phase + 3'd1;
    end

    task automatic send_word(input logic [OP_W-1:0] op, input logic signed [X_W-1:0] arg);
        int gap;
        if (burst_left == 0)
        begin
            gap        = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
            burst_left = ($urandom_range(0, 5) == 0) ? $urandom_range(100, 300)
                                                     : $urandom_range(1, 24);
            if (gap != 0)
            begin
                req_valid <= 1'b0;
                repeat (gap) @(negedge clk);
            end
        end
        burst_left--;
        req_valid <= 1'b1;
        operation <= op;
        argument  <= arg;
        @(posedge clk);
        while (req_stall)
            @(posedge clk);
        words_sent[op]++;
        @(negedge clk);
    endtask

    // hold off the sender until every word in flight has come back
    task automatic drain_results();
        req_valid <= 1'b0;
        @(negedge clk);
        while (outstanding != 0)
            @(negedge clk);
    endtask

    initial
    begin
        int idle_cycles;
        idle_cycles = 0;
        while (idle_cycles < IDLE_LIMIT)
        begin
            @(posedge clk);
            if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall))
                idle_cycles = 0;
            else
                idle_cycles++;
        end
        $display("watchdog: no word moved for %0d cycles", IDLE_LIMIT);
        $display("Regression FAIL");
        $finish;
    end

    initial
    begin
        logic [OP_W-1:0]       op;
        logic signed [X_W-1:0] arg;
        rst_n      = 1'b0;
        req_valid  = 1'b0;
        operation  = OP_SIN;
        argument   = '0;
        burst_left = 0;
        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        send_word(OP_SIN, '0);
        send_word(OP_SIN, X_W'(FX_PI_HALF));
        send_word(OP_SIN, X_W'(FX_PI_HALF + 1));
        send_word(OP_SIN, X_W'(FX_PI));
        send_word(OP_SIN, X_W'(FX_PI + 1));
        send_word(OP_SIN, X_W'(FX_PI_3HALF));
        send_word(OP_SIN, X_W'(FX_PI_3HALF + 1));
        send_word(OP_SIN, X_W'(FX_TWO_PI));
        send_word(OP_SIN, -20'sd1);
        send_word(OP_COS, X_W'(FX_PI_HALF));
        send_word(OP_COS, X_W'(FX_PI_HALF + 1));
        send_word(OP_COS, X_W'(FX_PI + 1));
        send_word(OP_COS, X_W'(FX_PI_3HALF + 1));
        send_word(OP_COS, ARG_MIN);
        send_word(OP_TAN, '0);
        send_word(OP_TAN, ARG_PI_QTR);
        send_word(OP_TAN, ARG_MAX);
        send_word(OP_TAN, ARG_MIN);
        send_word(OP_ATAN, -ARG_ONE);
        send_word(OP_ATAN, ARG_ONE);
        send_word(OP_ATAN, '0);
        send_word(OP_ATAN, ARG_MAX);
        send_word(OP_ATAN, ARG_MIN);
        drain_results();

        for (int i = 0; i < RANDOM_WORDS; i++)
        begin
            if (i == RANDOM_WORDS / 2)
                drain_results();
            op = OP_W'($urandom_range(0, 3));
            if ($urandom_range(0, 7) == 0)
                arg = X_W'($urandom);
            else
            begin
                case (op)
                    OP_SIN, OP_COS: arg = X_W'($urandom_range(0, FX_TWO_PI));
                    OP_TAN:         arg = X_W'($urandom_range(0, ARG_PI_QTR));
                    default:        arg = X_W'($urandom_range(0, 2 * ARG_ONE) - ARG_ONE);
                endcase
            end
            send_word(op, arg);
        end

        drain_results();
        repeat (TAIL_CYCLES) @(negedge clk);
        $display("Sent %0d sine, %0d cosine, %0d tangent, %0d arctangent words in bursts,",
                 words_sent[OP_SIN], words_sent[OP_COS], words_sent[OP_TAN],
                 words_sent[OP_ATAN]);
        $display("result side stalled on four patterns; %0d results checked, %0d mismatches.",
                 results_seen, mismatches);
        if (mismatches == 0 && outstanding == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule
